@@ rtl/core/udrb_pkg.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer package
// Operation codes and the control and status groups of one byte ring.
// ----------------------------------------------------------------------------
package udrb_pkg;

  // Item kinds carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_SERVICE = 2'd0,
    OP_WRITE   = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Requests to one ring for the current word.
  typedef struct packed {
    logic push;
    logic pop;
  } ring_ctrl_t;

  // Occupancy flags of one ring before the current word.
  typedef struct packed {
    logic full;
    logic empty;
  } ring_stat_t;

  // Bit positions of the input tdata fields.
  localparam int IN_OVR_BIT  = 0;
  localparam int IN_DR_BIT   = 1;
  localparam int IN_THRE_BIT = 2;
  localparam int IN_RXB_LSB  = 3;
  localparam int IN_TXB_LSB  = 11;
  localparam int IN_DATA_W   = 24;

endpackage

@@ rtl/core/uart_dual_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer
// Receive and transmit byte queues between a UART line and a host, with
// interrupt enable tracking and an overrun counter.
// ----------------------------------------------------------------------------
// Each input word is a line service event, a host write, a host read or an
// undecoded code, and gives exactly one result word. One word is accepted
// per clock unless the output stalls. Each word moves from the first stage
// to the output register. The first register stage holds the decision and
// the queue memories' registered read, the second is the output register.
// The rate is set by the single push or pop each queue takes per cycle. Store
// entries are not cleared after reset; they are only read once written.
module uart_dual_ring_buffer
  import udrb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  localparam int LW         = $clog2(QUEUE_DEPTH + 1),
  localparam int OUT_W      = ((22 + 2 * LW + 32 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // line_overrun, line_data_ready, line_tx_empty, line_rx_byte, host_tx_byte
  input  logic [IN_DATA_W-1:0] in_tdata,
  // operation
  input  logic [1:0]       in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  // read_valid, read_byte, write_accepted, line_rx_taken, line_tx_valid,
  // line_tx_byte, rx_irq_enable, tx_irq_enable, rx_level, tx_level,
  // overrun_total
  output logic [OUT_W-1:0] out_tdata
);

  localparam int OUT_BITS = 22 + 2 * LW + 32;

  op_t        op;
  logic       in_acc;
  logic       adv1;
  logic       ovr_bit, dr_bit, thre_bit;
  logic [7:0] rxb, txb;

  ring_ctrl_t rx_ctrl, tx_ctrl, rx_req, tx_req;
  ring_stat_t rx_stat, tx_stat;
  logic [LW-1:0] rx_lvl_nxt, tx_lvl_nxt;
  logic [7:0]    rx_rd_byte, tx_rd_byte;

  logic        rx_en_r, rx_en_nxt;
  logic        tx_en_r, tx_en_nxt;
  logic [31:0] ovr_cnt_r, ovr_cnt_nxt;
  logic        rv, wa, taken, txv;

  // First stage registers.
  logic          v1_r;
  logic          rv1_r, wa1_r, taken1_r, txv1_r, rxen1_r, txen1_r;
  logic [LW-1:0] rxlev1_r, txlev1_r;
  logic [31:0]   ovr1_r;

  // Output register.
  logic             out_v_r;
  logic [OUT_W-1:0] out_data_r;

  // Handshake: the first stage frees when it moves into the output register.
  assign adv1      = v1_r && (!out_v_r || out_tready);
  assign in_tready = !v1_r || adv1;
  assign in_acc    = in_tvalid && in_tready;

  // Field unpacking.
  assign op       = op_t'(in_tuser);
  assign ovr_bit  = in_tdata[IN_OVR_BIT];
  assign dr_bit   = in_tdata[IN_DR_BIT];
  assign thre_bit = in_tdata[IN_THRE_BIT];
  assign rxb      = in_tdata[IN_RXB_LSB +: 8];
  assign txb      = in_tdata[IN_TXB_LSB +: 8];

  // Decision for one word against the queue state.
  always_comb begin
    rx_req      = '0;
    tx_req      = '0;
    rv          = 1'b0;
    wa          = 1'b0;
    taken       = 1'b0;
    txv         = 1'b0;
    rx_en_nxt   = rx_en_r;
    tx_en_nxt   = tx_en_r;
    ovr_cnt_nxt = ovr_cnt_r;
    unique case (op)
      OP_SERVICE: begin
        if (ovr_bit) ovr_cnt_nxt = ovr_cnt_r + 32'd1;
        if (dr_bit) begin
          if (!rx_stat.full) begin
            rx_req.push = 1'b1;
            taken       = 1'b1;
          end else begin
            rx_en_nxt = 1'b0;
          end
        end
        if (thre_bit) begin
          if (!tx_stat.empty) begin
            tx_req.pop = 1'b1;
            txv        = 1'b1;
          end else begin
            tx_en_nxt = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        if (!tx_stat.full) begin
          tx_req.push = 1'b1;
          tx_en_nxt   = 1'b1;
          wa          = 1'b1;
        end
      end
      OP_READ: begin
        if (!rx_stat.empty) begin
          rx_req.pop = 1'b1;
          rx_en_nxt  = 1'b1;
          rv         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rx_ctrl = in_acc ? rx_req : '0;
  assign tx_ctrl = in_acc ? tx_req : '0;

  udrb_ring #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_rx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (rx_ctrl),
    .wr_byte   (rxb),
    .stat      (rx_stat),
    .level_nxt (rx_lvl_nxt),
    .rd_byte   (rx_rd_byte)
  );

  udrb_ring #(.DEPTH(QUEUE_DEPTH), .LW(LW)) u_tx_ring (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tx_ctrl),
    .wr_byte   (txb),
    .stat      (tx_stat),
    .level_nxt (tx_lvl_nxt),
    .rd_byte   (tx_rd_byte)
  );

  // Enable flags and overrun counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_en_r   <= 1'b1;
      tx_en_r   <= 1'b0;
      ovr_cnt_r <= '0;
    end else if (in_acc) begin
      rx_en_r   <= rx_en_nxt;
      tx_en_r   <= tx_en_nxt;
      ovr_cnt_r <= ovr_cnt_nxt;
    end
  end

  // First stage: the result of the word minus the popped bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rv1_r    <= rv;
      wa1_r    <= wa;
      taken1_r <= taken;
      txv1_r   <= txv;
      rxen1_r  <= rx_en_nxt;
      txen1_r  <= tx_en_nxt;
      rxlev1_r <= rx_lvl_nxt;
      txlev1_r <= tx_lvl_nxt;
      ovr1_r   <= ovr_cnt_nxt;
    end
  end

  // Output register: popped bytes join the word here.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv1) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      out_data_r <= OUT_W'({ovr1_r, txlev1_r, rxlev1_r, txen1_r, rxen1_r,
                            (txv1_r ? tx_rd_byte : 8'd0), txv1_r, taken1_r,
                            wa1_r, (rv1_r ? rx_rd_byte : 8'd0), rv1_r});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  // A word never both reads and writes.
  a_one_host_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> !(out_data_r[0] && out_data_r[9]))
    else $error("read and write reported in one result word");

  // An accepted write to a queue with room enables the transmit interrupt.
  a_write_enables_tx: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && op == OP_WRITE && !tx_stat.full) |=> tx_en_r)
    else $error("accepted write did not set the transmit enable");

  // A stalled first stage keeps its word.
  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !adv1) |=> (v1_r && $stable(ovr1_r) && $stable(rxlev1_r)
                         && $stable(txlev1_r)))
    else $error("first stage changed while stalled");

  // Levels never exceed the queue depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (rxlev1_r <= LW'(QUEUE_DEPTH) && txlev1_r <= LW'(QUEUE_DEPTH)))
    else $error("queue level beyond depth");

  // The packed result fits the port.
  a_width_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (OUT_BITS <= OUT_W))
    else $error("result word wider than the port");

endmodule

@@ rtl/core/udrb_ring.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer byte ring
// One byte queue with free-running head and tail counters, a level register
// and a registered read port.
// ----------------------------------------------------------------------------
module udrb_ring
  import udrb_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int LW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  ring_ctrl_t    ctrl,
  input  logic [7:0]    wr_byte,
  output ring_stat_t    stat,
  output logic [LW-1:0] level_nxt,
  output logic [7:0]    rd_byte
);

  localparam int CW = $clog2(2 * DEPTH);
  localparam int SW = $clog2(DEPTH);
  localparam logic [CW-1:0] CTR_LAST = CW'(2 * DEPTH - 1);
  localparam logic [CW-1:0] CTR_HALF = CW'(DEPTH);
  localparam logic [LW-1:0] LVL_FULL = LW'(DEPTH);

  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] tail_r, tail_nxt;
  logic [LW-1:0] level_r;
  logic [SW-1:0] head_slot, tail_slot;
  logic [7:0]    store [DEPTH];
  logic [7:0]    rd_byte_r;

  // Counters run modulo twice the depth; the slot folds the upper half down.
  always_comb begin
    head_nxt  = (head_r == CTR_LAST) ? '0 : head_r + 1'b1;
    tail_nxt  = (tail_r == CTR_LAST) ? '0 : tail_r + 1'b1;
    head_slot = (head_r >= CTR_HALF) ? SW'(head_r - CTR_HALF) : SW'(head_r);
    tail_slot = (tail_r >= CTR_HALF) ? SW'(tail_r - CTR_HALF) : SW'(tail_r);
  end

  // Status before this word and level after it.
  always_comb begin
    stat.full  = (level_r == LVL_FULL);
    stat.empty = (level_r == '0);
    level_nxt  = level_r + LW'(ctrl.push) - LW'(ctrl.pop);
  end

  // Pointer and level state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      level_r <= '0;
    end else begin
      if (ctrl.push) tail_r <= tail_nxt;
      if (ctrl.pop)  head_r <= head_nxt;
      level_r <= level_nxt;
    end
  end

  // Byte store with a registered read that holds until the next pop.
  always_ff @(posedge clk) begin
    if (ctrl.push) store[tail_slot] <= wr_byte;
    if (ctrl.pop)  rd_byte_r <= store[head_slot];
  end

  assign rd_byte = rd_byte_r;

endmodule

@@ dv/udrb_reply_checker.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer reply checker
// Watches both stream channels, keeps its own copy of the two byte queues,
// the interrupt enables and the overrun count, and compares every reply word
// against the reply predicted for the oldest outstanding request word.
// ----------------------------------------------------------------------------
module udrb_reply_checker
  import udrb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64,
  parameter int OUT_W       = 72
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic [1:0]           in_tuser,
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [OUT_W-1:0]     out_tdata,
  output int                   mismatches,
  output int                   pending
);

  // Counters run modulo twice the depth, so they carry one extra bit.
  localparam int PTR_W = $clog2(QUEUE_DEPTH) + 1;
  localparam logic [PTR_W-1:0] FULL_LEVEL = PTR_W'(QUEUE_DEPTH);

  // Reply fields, listed from the top bit down so read_valid lands in bit 0.
  typedef struct packed {
    logic [31:0] overrun_total;
    logic [6:0]  tx_level;
    logic [6:0]  rx_level;
    logic        tx_irq_enable;
    logic        rx_irq_enable;
    logic [7:0]  line_tx_byte;
    logic        line_tx_valid;
    logic        line_rx_taken;
    logic        write_accepted;
    logic [7:0]  read_byte;
    logic        read_valid;
  } reply_t;

  localparam int REPLY_W = $bits(reply_t);

  // Shadow copy of the block state.
  logic [7:0]       rx_mem [QUEUE_DEPTH];
  logic [7:0]       tx_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] rx_head, rx_tail;
  logic [PTR_W-1:0] tx_head, tx_tail;
  logic [31:0]      overrun_cnt;
  logic             rx_ie, tx_ie;

  // Replies predicted but not yet seen on the output channel.
  reply_t awaited_replies[$];

  // Apply one request word to the shadow queues and build its reply.
  task automatic advance_queues(input logic [1:0] op, input logic [IN_DATA_W-1:0] d,
                                output reply_t r);
    logic [PTR_W-1:0] rx_lvl;
    logic [PTR_W-1:0] tx_lvl;
    r = '0;
    rx_lvl = rx_tail - rx_head;
    tx_lvl = tx_tail - tx_head;
    case (op)
      OP_SERVICE: begin
        if (d[IN_OVR_BIT]) overrun_cnt = overrun_cnt + 32'd1;
        // A received byte is dropped when the receive queue is full.
        if (d[IN_DR_BIT]) begin
          if (rx_lvl != FULL_LEVEL) begin
            rx_mem[rx_tail[PTR_W-2:0]] = d[IN_RXB_LSB +: 8];
            rx_tail = rx_tail + 1'b1;
            r.line_rx_taken = 1'b1;
          end else begin
            rx_ie = 1'b0;
          end
        end
        // An empty holding register drains one byte, or stops the interrupt.
        if (d[IN_THRE_BIT]) begin
          if (tx_lvl != '0) begin
            r.line_tx_byte = tx_mem[tx_head[PTR_W-2:0]];
            r.line_tx_valid = 1'b1;
            tx_head = tx_head + 1'b1;
          end else begin
            tx_ie = 1'b0;
          end
        end
      end
      OP_WRITE: begin
        if (tx_lvl != FULL_LEVEL) begin
          tx_mem[tx_tail[PTR_W-2:0]] = d[IN_TXB_LSB +: 8];
          tx_tail = tx_tail + 1'b1;
          tx_ie = 1'b1;
          r.write_accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (rx_lvl != '0) begin
          r.read_byte = rx_mem[rx_head[PTR_W-2:0]];
          r.read_valid = 1'b1;
          rx_head = rx_head + 1'b1;
          rx_ie = 1'b1;
        end
      end
      default: begin
        // The unused code leaves the state alone and reports status only.
      end
    endcase
    r.rx_irq_enable = rx_ie;
    r.tx_irq_enable = tx_ie;
    r.rx_level      = 7'(rx_tail - rx_head);
    r.tx_level      = 7'(tx_tail - tx_head);
    r.overrun_total = overrun_cnt;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_reply(input reply_t want, input reply_t got);
    check_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
    check_field("read_byte", 32'(want.read_byte), 32'(got.read_byte));
    check_field("write_accepted", 32'(want.write_accepted), 32'(got.write_accepted));
    check_field("line_rx_taken", 32'(want.line_rx_taken), 32'(got.line_rx_taken));
    check_field("line_tx_valid", 32'(want.line_tx_valid), 32'(got.line_tx_valid));
    check_field("line_tx_byte", 32'(want.line_tx_byte), 32'(got.line_tx_byte));
    check_field("rx_irq_enable", 32'(want.rx_irq_enable), 32'(got.rx_irq_enable));
    check_field("tx_irq_enable", 32'(want.tx_irq_enable), 32'(got.tx_irq_enable));
    check_field("rx_level", 32'(want.rx_level), 32'(got.rx_level));
    check_field("tx_level", 32'(want.tx_level), 32'(got.tx_level));
    check_field("overrun_total", want.overrun_total, got.overrun_total);
  endtask

  // Predict on each accepted request word, then match each accepted reply word.
  always @(posedge clk) begin : watch
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      rx_head     = '0;
      rx_tail     = '0;
      tx_head     = '0;
      tx_tail     = '0;
      overrun_cnt = '0;
      rx_ie       = 1'b1;
      tx_ie       = 1'b0;
      awaited_replies.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        advance_queues(in_tuser, in_tdata, want);
        awaited_replies.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = reply_t'(out_tdata[REPLY_W-1:0]);
        if (awaited_replies.size() == 0) begin
          $error("reply word %0h arrived with none outstanding", out_tdata);
          mismatches++;
        end else begin
          want = awaited_replies.pop_front();
          compare_reply(want, got);
        end
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

@@ dv/uart_dual_ring_buffer_tb.sv @@
// ----------------------------------------------------------------------------
// UART dual ring buffer testbench
// Drives line service events, host writes and host reads with random gaps and
// output stalls, fills and drains both queues past their limits, and leaves
// the prediction and comparison to the reply checker.
// ----------------------------------------------------------------------------
module uart_dual_ring_buffer_tb;
  import udrb_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int QUEUE_DEPTH  = 64;
  localparam int LVL_W        = $clog2(QUEUE_DEPTH + 1);
  // Reply fields padded up to whole bytes.
  localparam int OUT_W        = ((22 + 2 * LVL_W + 32 + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 1130;
  localparam int LONG_HOLD    = 300;
  localparam int PACE_SPAN    = 40;

  // Operation code that the block does not decode.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Idle patterns of one side of the stream.
  typedef enum int {
    PACE_NONE,
    PACE_FULL,
    PACE_RARE
  } pace_t;

  // Request mixes of one random segment.
  typedef enum int {
    MIX_BALANCED,
    MIX_RX_FILL,
    MIX_RX_DRAIN,
    MIX_TX_FILL,
    MIX_TX_DRAIN
  } mix_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [1:0]           in_tuser;
  logic                 out_tvalid;
  logic                 out_tready;
  logic [OUT_W-1:0]     out_tdata;
  int                   mismatches;
  int                   pending;

  int    words_sent = 0;
  pace_t send_pace  = PACE_FULL;

  uart_dual_ring_buffer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  udrb_reply_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .OUT_W       (OUT_W)
  ) reply_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int draw_gap(input pace_t pace);
    case (pace)
      PACE_NONE: return 0;
      PACE_FULL: return $urandom_range(0, 14);
      default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 14) : 0;
    endcase
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_line(input logic ovr, input logic dr,
                                                     input logic thre, input logic [7:0] rxb,
                                                     input logic [7:0] txb);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[IN_OVR_BIT]      = ovr;
    d[IN_DR_BIT]       = dr;
    d[IN_THRE_BIT]     = thre;
    d[IN_RXB_LSB +: 8] = rxb;
    d[IN_TXB_LSB +: 8] = txb;
    return d;
  endfunction

  // Offer one request word after a random gap and hold it until accepted.
  task automatic offer_word(input logic [1:0] op, input logic [IN_DATA_W-1:0] data);
    int gap;
    gap = draw_gap(send_pace);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (words_sent % PACE_SPAN == 0) send_pace = pace_t'($urandom_range(PACE_NONE, PACE_RARE));
  endtask

  // Draw one request word biased toward the segment's mix.
  task automatic make_word(input mix_t mix, output logic [1:0] op,
                           output logic [IN_DATA_W-1:0] data);
    int   roll;
    logic ovr;
    logic dr;
    logic thre;
    roll = $urandom_range(0, 99);
    ovr  = 1'($urandom_range(0, 1));
    dr   = 1'($urandom_range(0, 1));
    thre = 1'($urandom_range(0, 1));
    op   = OP_SERVICE;
    case (mix)
      MIX_RX_FILL: begin
        if (roll < 85) dr = 1'b1;
        else op = (roll < 93) ? OP_READ : OP_WRITE;
      end
      MIX_RX_DRAIN: begin
        if (roll < 80) op = OP_READ;
      end
      MIX_TX_FILL: begin
        if (roll < 80) op = OP_WRITE;
      end
      MIX_TX_DRAIN: begin
        if (roll < 80) thre = 1'b1;
        else op = (roll < 90) ? OP_WRITE : OP_READ;
      end
      default: begin
        op = 2'($urandom_range(OP_SERVICE, OP_READ));
      end
    endcase
    // A sprinkle of words with the undecoded operation code.
    if (roll >= 98) op = OP_UNUSED;
    data = pack_line(ovr, dr, thre, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  // Request side: reset, directed words, random segments, then drain.
  initial begin : stimulus
    logic [1:0]           op;
    logic [IN_DATA_W-1:0] data;
    mix_t                 mix;
    int                   seg_left;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_SERVICE;
    mix       = MIX_BALANCED;
    seg_left  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reads and transmit drains on empty queues are rejected.
    offer_word(OP_READ, pack_line(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    offer_word(OP_SERVICE, pack_line(1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    // Extreme bytes through the transmit queue.
    offer_word(OP_WRITE, pack_line(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    offer_word(OP_WRITE, pack_line(1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF));
    // Service with every status bit set, then drain the transmit queue dry.
    offer_word(OP_SERVICE, pack_line(1'b1, 1'b1, 1'b1, 8'hFF, 8'h00));
    offer_word(OP_SERVICE, pack_line(1'b0, 1'b1, 1'b1, 8'h00, 8'hFF));
    offer_word(OP_SERVICE, pack_line(1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    // Drain the receive queue and read once more past empty.
    offer_word(OP_READ, pack_line(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF));
    offer_word(OP_READ, pack_line(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    offer_word(OP_READ, pack_line(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));
    // Undecoded operation with every data bit set.
    offer_word(OP_UNUSED, '1);
    offer_word(OP_UNUSED, '0);
    // Overrun alone, a service with nothing set, and ignored fields.
    offer_word(OP_SERVICE, pack_line(1'b1, 1'b0, 1'b0, 8'h00, 8'h00));
    offer_word(OP_SERVICE, pack_line(1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF));
    offer_word(OP_WRITE, pack_line(1'b1, 1'b1, 1'b1, 8'hFF, 8'h5A));
    offer_word(OP_SERVICE, pack_line(1'b1, 1'b1, 1'b0, 8'hA5, 8'hFF));
    offer_word(OP_SERVICE, pack_line(1'b0, 1'b0, 1'b1, 8'h00, 8'h00));
    offer_word(OP_READ, pack_line(1'b0, 1'b0, 1'b0, 8'h00, 8'h00));

    // Random segments, each leaning toward filling or draining one queue.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (seg_left == 0) begin
        mix      = mix_t'($urandom_range(MIX_BALANCED, MIX_TX_DRAIN));
        seg_left = $urandom_range(30, 140);
      end
      seg_left--;
      make_word(mix, op, data);
      offer_word(op, data);
    end
    in_tvalid <= 1'b0;

    // Wait for every outstanding reply, then allow a few more cycles.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Reply side: random stalls, with two long holds that back up the input.
  initial begin : reply_sink
    int    stall;
    int    taken;
    pace_t pace;
    out_tready = 1'b0;
    taken      = 0;
    pace       = PACE_FULL;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken == 0 || taken == 600) stall = LONG_HOLD;
      else stall = draw_gap(pace);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
      if (taken % PACE_SPAN == 0) pace = pace_t'($urandom_range(PACE_NONE, PACE_RARE));
    end
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #(CLK_PERIOD * 300000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
